/* rtl/rrq_pkg.sv */
// Shared types, constants and codes of the round robin ready queue scheduler.
package rrq_pkg;

  localparam int unsigned ThreadIdW        = 4;
  localparam int unsigned PrioW            = 8;
  localparam int unsigned MaxThreads       = 16;
  localparam int unsigned NumThreadsDefault = 16;
  localparam logic [PrioW-1:0] MainPrioReset = 8'd31;

  typedef logic [ThreadIdW-1:0] tid_t;
  typedef logic [PrioW-1:0]     prio_t;

  typedef enum logic {
    KIND_CREATE   = 1'b0,
    KIND_SCHEDULE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_EMPTY  = 2'd1,
    ERR_IN_USE = 2'd2
  } err_e;

  // queue control from the scheduler to the ready queue
  typedef struct packed {
    logic push;
    logic pop;
  } rrq_qctl_t;

endpackage

/* rtl/round_robin_ready_queue_core.sv */
// Top level of the round robin thread scheduler with a FIFO ready queue.
//
// Thread scheduler with a FIFO ready queue held in one synchronous memory.
// After reset thread 0 runs with priority and tick budget main_priority
// (31 by default) and is not queued. A create request (kind 0) marks an
// unused thread as used and appends it, with its priority, to the queue
// tail; a used id or an id at or beyond NUM_THREADS gives error 2. A
// schedule request (kind 1) appends the running thread to the tail unless
// current_blocked is set, then pops the head and runs it; a blocked thread
// with an empty queue gives error 1 and the current thread keeps running.
// Every request gives exactly one result: the running thread, its tick
// budget (always equal to its priority, since ticks are only reloaded) and
// the error code. Timing: the accept edge updates the queue pointers, writes
// a pushed entry and launches the read of the head entry; the next cycle
// takes the read data and loads the result register, but stalls while the
// result register still holds an untaken result. Writing main_priority also
// sets thread 0's priority, also for a thread 0 that currently sits in the
// queue; the user must make writes only while the block is idle, which the
// block does not enforce. No clearing pass is needed after reset.
module round_robin_ready_queue_core #(
  parameter int unsigned NUM_THREADS = rrq_pkg::NumThreadsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rrq_pkg::PrioW-1:0]      cfg_main_priority_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [rrq_pkg::ThreadIdW-1:0]  thread_id_i,
  input  logic [rrq_pkg::PrioW-1:0]      priority_req_i,
  input  logic                           current_blocked_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rrq_pkg::ThreadIdW-1:0]  next_thread_o,
  output logic [rrq_pkg::PrioW-1:0]      next_ticks_o,
  output logic [1:0]                     error_o
);
  import rrq_pkg::*;

  // thread ids are 4 bits wide, so at most 16 threads ever exist
  localparam int unsigned NumSlots = (NUM_THREADS < MaxThreads) ? NUM_THREADS : MaxThreads;
  localparam int unsigned IdxW     = $clog2(NumSlots);
  localparam int unsigned EntryW   = IdxW + PrioW;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_e;

  state_e             state_q;
  logic [NumSlots-1:0] used_q;
  logic [IdxW-1:0]    cur_q;
  prio_t              cur_prio_q;
  prio_t              main_prio_q;
  logic               pend_pop_q;
  err_e               pend_err_q;
  logic               out_valid_q;
  tid_t               out_thread_q;
  prio_t              out_ticks_q;
  err_e               out_err_q;

  logic               in_acc;
  logic               out_free;
  logic               is_create;
  logic               id_in_range;
  logic [IdxW-1:0]    id_idx;
  logic               create_ok;
  logic               q_empty;
  rrq_qctl_t          qctl;
  logic [EntryW-1:0]  q_wdata;
  logic [EntryW-1:0]  q_rdata;
  logic [IdxW-1:0]    pop_id;
  prio_t              pop_prio;
  logic [IdxW-1:0]    nxt_id;
  prio_t              nxt_prio;
  err_e               req_err;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // request decode
  assign is_create   = (kind_e'(kind_i) == KIND_CREATE);
  assign id_in_range = (32'(thread_id_i) < NUM_THREADS);
  assign id_idx      = thread_id_i[IdxW-1:0];
  assign create_ok   = id_in_range && !used_q[id_idx];

  always_comb begin
    qctl.push = 1'b0;
    qctl.pop  = 1'b0;
    req_err   = ERR_OK;
    if (is_create) begin
      qctl.push = in_acc && create_ok;
      if (!create_ok) begin
        req_err = ERR_IN_USE;
      end
    end else begin
      // an empty queue with a runnable thread: it is neither requeued nor
      // popped, so nothing in the queue changes
      qctl.pop  = in_acc && !q_empty;
      qctl.push = in_acc && !q_empty && !current_blocked_i;
      if (current_blocked_i && q_empty) begin
        req_err = ERR_EMPTY;
      end
    end
  end

  assign q_wdata = is_create ? {id_idx, priority_req_i} : {cur_q, cur_prio_q};

  rrq_ready_queue #(
    .Depth (NumSlots),
    .DataW (EntryW)
  ) u_ready_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (qctl),
    .wdata_i (q_wdata),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign pop_id   = q_rdata[EntryW-1:PrioW];
  assign pop_prio = q_rdata[PrioW-1:0];
  assign nxt_id   = pend_pop_q ? pop_id : cur_q;
  // thread 0 always carries the live main priority
  assign nxt_prio = (nxt_id == '0) ? main_prio_q : (pend_pop_q ? pop_prio : cur_prio_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= NumSlots'(1);
      cur_q        <= '0;
      cur_prio_q   <= MainPrioReset;
      main_prio_q  <= MainPrioReset;
      pend_pop_q   <= 1'b0;
      pend_err_q   <= ERR_OK;
      out_valid_q  <= 1'b0;
      out_thread_q <= '0;
      out_ticks_q  <= '0;
      out_err_q    <= ERR_OK;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        main_prio_q <= cfg_main_priority_i;
      end
      // in ST_FINISH a taken result is replaced below
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_create && create_ok) begin
              used_q[id_idx] <= 1'b1;
            end
            pend_pop_q <= qctl.pop;
            pend_err_q <= req_err;
            state_q    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            cur_q        <= nxt_id;
            cur_prio_q   <= nxt_prio;
            out_valid_q  <= 1'b1;
            out_thread_q <= ThreadIdW'(nxt_id);
            out_ticks_q  <= nxt_prio;
            out_err_q    <= pend_err_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_thread_o = out_thread_q;
  assign next_ticks_o  = out_ticks_q;
  assign error_o       = out_err_q;

endmodule

/* rtl/rrq_ready_queue.sv */
// Ready queue: circular FIFO in a synchronous memory with registered read data.
module rrq_ready_queue #(
  parameter int unsigned Depth = rrq_pkg::MaxThreads,
  parameter int unsigned DataW = rrq_pkg::ThreadIdW + rrq_pkg::PrioW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrq_pkg::rrq_qctl_t ctl_i,
  input  logic [DataW-1:0]  wdata_i,
  output logic [DataW-1:0]  rdata_o,
  output logic              empty_o
);
  import rrq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;
  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (count_q == '0);
  assign do_push = ctl_i.push && (count_q != FullCnt);
  assign do_pop  = ctl_i.pop && !empty_o;
  assign rdata_o = rdata_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_push) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
    end
    if (do_pop) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // push and pop never touch the same entry: a pop needs a non-empty queue
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_q] <= wdata_i;
    end
    if (do_pop) begin
      rdata_q <= mem[head_q];
    end
  end

endmodule
